/* src/sns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_pkg
// Shared types and constants for the Sobel non-maximum suppression block.
// ----------------------------------------------------------------------------
package sns_pkg;

  // Register map (word index)
  localparam int unsigned REG_IMAGE_WIDTH = 0;

  localparam logic [10:0] WIDTH_RESET = 11'd640;
  localparam int unsigned MIN_WIDTH   = 5;

  // Fixed-point constants: 181/1024 ~ 1/(4*sqrt2), 106/256 ~ tan 22.5, 618/256 ~ tan 67.5
  localparam logic [7:0]  MAG_SCALE = 8'd181;
  localparam logic [6:0]  TAN_LO    = 7'd106;
  localparam logic [9:0]  TAN_HI    = 10'd618;

  // Direction sectors
  localparam logic [1:0] SEC_HORZ      = 2'd0;
  localparam logic [1:0] SEC_DIAG_SAME = 2'd1;
  localparam logic [1:0] SEC_VERT      = 2'd2;
  localparam logic [1:0] SEC_DIAG_OPP  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WIN,
    ST_GRAD,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_MAG,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic win;
    logic grad;
    logic square;
    logic sum;
    logic sqrt_step;
    logic mag;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic emit_req;
    logic out_free;
  } status_t;

endpackage

/* src/sns_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/sns_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_ctrl
// Sequencer: steps one item through read, window, gradient, root and emit.
// ----------------------------------------------------------------------------
module sns_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sns_pkg::status_t stat,
  output sns_pkg::cmd_t   cmd
);

  sns_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sns_pkg::ST_IDLE:   if (in_valid) state_next = sns_pkg::ST_READ;
      sns_pkg::ST_READ:   state_next = sns_pkg::ST_WIN;
      sns_pkg::ST_WIN:    state_next = sns_pkg::ST_GRAD;
      sns_pkg::ST_GRAD:   state_next = sns_pkg::ST_SQUARE;
      sns_pkg::ST_SQUARE: state_next = sns_pkg::ST_SUM;
      sns_pkg::ST_SUM:    state_next = sns_pkg::ST_SQRT;
      sns_pkg::ST_SQRT:   if (stat.sqrt_done) state_next = sns_pkg::ST_MAG;
      sns_pkg::ST_MAG:    state_next = sns_pkg::ST_UPDATE;
      sns_pkg::ST_UPDATE: state_next = sns_pkg::ST_EMIT;
      sns_pkg::ST_EMIT: begin
        if (!stat.emit_req || stat.out_free) state_next = sns_pkg::ST_IDLE;
      end
      default:            state_next = sns_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      sns_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      sns_pkg::ST_WIN:    cmd.win       = 1'b1;
      sns_pkg::ST_GRAD:   cmd.grad      = 1'b1;
      sns_pkg::ST_SQUARE: cmd.square    = 1'b1;
      sns_pkg::ST_SUM:    cmd.sum       = 1'b1;
      sns_pkg::ST_SQRT:   cmd.sqrt_step = 1'b1;
      sns_pkg::ST_MAG:    cmd.mag       = 1'b1;
      sns_pkg::ST_UPDATE: cmd.update    = 1'b1;
      sns_pkg::ST_EMIT:   cmd.load_out  = stat.emit_req && stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/sns_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_datapath
// Line buffers, Sobel window, iterative root, sector and suppression logic.
// ----------------------------------------------------------------------------
module sns_datapath #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [10:0]      image_width,
  input  logic [7:0]       pixel,
  input  logic             frame_start,
  input  sns_pkg::cmd_t    cmd,
  output sns_pkg::status_t stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       edge_value,
  output logic [9:0]       out_row,
  output logic [9:0]       out_col,
  output logic [1:0]       sector
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned UW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

  // clamped width
  logic [UW-1:0] iw_ext, w_used;
  assign iw_ext = UW'(image_width);
  always_comb begin
    if (iw_ext < UW'(sns_pkg::MIN_WIDTH))  w_used = UW'(sns_pkg::MIN_WIDTH);
    else if (iw_ext > UW'(MAX_WIDTH))      w_used = UW'(MAX_WIDTH);
    else                                   w_used = iw_ext;
  end

  // counters and latched item
  logic [9:0]    row_cnt, r_cur;
  logic [AW-1:0] col_cnt, c_cur, mc;
  logic [7:0]    px_l;
  logic [9:0]    r0;
  logic [AW-1:0] c0;

  always_comb begin
    r0 = frame_start ? '0 : row_cnt;
    c0 = frame_start ? '0 : col_cnt;
    if (UW'(c0) >= w_used) begin
      c0 = '0;
      r0 = r0 + 10'd1;
    end
  end

  assign mc = c_cur - AW'(1);

  // line buffer RAMs
  logic [7:0] prow0_q, prow1_q, mrow0_q, mrow1_q;
  logic [1:0] srow_q;
  logic [7:0] mag_g;
  logic [1:0] sec_g;
  logic       cnz;
  assign cnz = (c_cur != '0);

  sns_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prow0 (
    .clk(clk), .we(cmd.win), .waddr(c_cur), .wdata(prow1_q), .raddr(c_cur), .rdata(prow0_q)
  );
  sns_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prow1 (
    .clk(clk), .we(cmd.win), .waddr(c_cur), .wdata(px_l), .raddr(c_cur), .rdata(prow1_q)
  );
  sns_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mrow0 (
    .clk(clk), .we(cmd.update && cnz), .waddr(mc), .wdata(mrow1_q), .raddr(mc),
    .rdata(mrow0_q)
  );
  sns_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mrow1 (
    .clk(clk), .we(cmd.update && cnz), .waddr(mc), .wdata(mag_g), .raddr(mc),
    .rdata(mrow1_q)
  );
  sns_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_srow (
    .clk(clk), .we(cmd.update && cnz), .waddr(mc), .wdata(sec_g), .raddr(mc),
    .rdata(srow_q)
  );

  // pixel window
  logic [7:0] pw [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pw[k][j] <= '0;
        end
      end
    end else if (cmd.win) begin
      for (int k = 0; k < 3; k++) begin
        pw[k][0] <= pw[k][1];
        pw[k][1] <= pw[k][2];
      end
      pw[0][2] <= prow0_q;
      pw[1][2] <= prow1_q;
      pw[2][2] <= px_l;
    end
  end

  // Sobel gradient
  logic signed [11:0] p00, p01, p02, p10, p12, p20, p21, p22, gx, gy;
  logic [10:0] ax, ay;
  logic        same_sign;

  always_comb begin
    p00 = $signed({4'b0, pw[0][0]});
    p01 = $signed({4'b0, pw[0][1]});
    p02 = $signed({4'b0, pw[0][2]});
    p10 = $signed({4'b0, pw[1][0]});
    p12 = $signed({4'b0, pw[1][2]});
    p20 = $signed({4'b0, pw[2][0]});
    p21 = $signed({4'b0, pw[2][1]});
    p22 = $signed({4'b0, pw[2][2]});
    gx  = 12'sd2 * (p12 - p10) - p00 - p20 + p02 + p22;
    gy  = 12'sd2 * (p21 - p01) - p00 - p02 + p20 + p22;
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      ax        <= gx[11] ? 11'(-gx) : 11'(gx);
      ay        <= gy[11] ? 11'(-gy) : 11'(gy);
      same_sign <= ((gx > 12'sd0) == (gy > 12'sd0));
    end
  end

  // squares and sector
  logic [21:0] ax2, ay2;
  logic [1:0]  sec_r;
  logic [20:0] a_cmp, b_cmp, c_cmp;

  always_comb begin
    a_cmp = {2'b0, ay[10:0], 8'b0};
    b_cmp = 21'(ax) * 21'(sns_pkg::TAN_LO);
    c_cmp = 21'(ax) * 21'(sns_pkg::TAN_HI);
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      ax2 <= ax * ax;
      ay2 <= ay * ay;
      if (a_cmp <= b_cmp)      sec_r <= sns_pkg::SEC_HORZ;
      else if (a_cmp <= c_cmp) sec_r <= same_sign ? sns_pkg::SEC_DIAG_SAME
                                                  : sns_pkg::SEC_DIAG_OPP;
      else                     sec_r <= sns_pkg::SEC_VERT;
    end
  end

  // iterative integer root, two bits of the radicand a step
  logic [21:0] sq_v, sq_root, sq_bit, sq_trial;
  assign sq_trial = sq_root + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_bit <= '0;
    end else if (cmd.sum) begin
      sq_v    <= ax2 + ay2;
      sq_root <= '0;
      sq_bit  <= 22'(1) << 20;
    end else if (cmd.sqrt_step && sq_bit != '0) begin
      if (sq_v >= sq_trial) begin
        sq_v    <= sq_v - sq_trial;
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // scaled magnitude, gated to pixels with a full window
  logic [18:0] mag_prod;
  logic        grad_ok;
  assign mag_prod = sq_root[10:0] * sns_pkg::MAG_SCALE;
  assign grad_ok  = cnz && (r_cur >= 10'd2) && (c_cur >= AW'(2));

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      if (!grad_ok)                mag_g <= '0;
      else if (mag_prod[18])       mag_g <= 8'hFF;
      else                         mag_g <= mag_prod[17:10];
      sec_g <= grad_ok ? sec_r : sns_pkg::SEC_HORZ;
    end
  end

  // magnitude and sector windows
  logic [7:0] mw [3][3];
  logic [7:0] mw_next [3][3];
  logic [1:0] sw [3];
  logic [1:0] sw_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mw_next[k][0] = mw[k][1];
      mw_next[k][1] = mw[k][2];
    end
    mw_next[0][2] = cnz ? mrow0_q : 8'd0;
    mw_next[1][2] = cnz ? mrow1_q : 8'd0;
    mw_next[2][2] = cnz ? mag_g   : 8'd0;
    sw_next[0]    = sw[1];
    sw_next[1]    = sw[2];
    sw_next[2]    = cnz ? srow_q : sns_pkg::SEC_HORZ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        sw[k] <= '0;
        for (int j = 0; j < 3; j++) begin
          mw[k][j] <= '0;
        end
      end
    end else if (cmd.update) begin
      mw <= mw_next;
      sw <= sw_next;
    end
  end

  // suppression and result position
  logic [7:0] n1, n2, ctr;
  logic [1:0] sec_c;
  logic       emit;
  logic [9:0] res_y, res_x;

  always_comb begin
    ctr   = mw_next[1][1];
    sec_c = sw_next[1];
    case (sec_c)
      sns_pkg::SEC_HORZ:      begin n1 = mw_next[1][0]; n2 = mw_next[1][2]; end
      sns_pkg::SEC_DIAG_SAME: begin n1 = mw_next[0][0]; n2 = mw_next[2][2]; end
      sns_pkg::SEC_VERT:      begin n1 = mw_next[0][1]; n2 = mw_next[2][1]; end
      default:                begin n1 = mw_next[2][0]; n2 = mw_next[0][2]; end
    endcase
    emit  = 1'b0;
    res_y = r_cur - 10'd2;
    res_x = 10'(c_cur - AW'(2));
    if (!cnz && r_cur >= 10'd4) begin
      emit  = 1'b1;
      res_y = r_cur - 10'd3;
      res_x = 10'(w_used - UW'(2));
    end else if (c_cur >= AW'(3) && r_cur >= 10'd3) begin
      emit  = 1'b1;
    end
  end

  logic [7:0] pend_val;
  logic [9:0] pend_y, pend_x;
  logic [1:0] pend_sec;
  logic       pend_emit;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      pend_val <= (ctr >= n1 && ctr >= n2) ? ctr : 8'd0;
      pend_y   <= res_y;
      pend_x   <= res_x;
      pend_sec <= sec_c;
    end
  end

  // counters: latch on accept, advance on update
  logic [UW-1:0] c_inc;
  assign c_inc = UW'(c_cur) + UW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      col_cnt   <= '0;
      pend_emit <= 1'b0;
    end else begin
      if (cmd.update) begin
        pend_emit <= emit;
        if (c_inc >= w_used) begin
          col_cnt <= '0;
          row_cnt <= r_cur + 10'd1;
        end else begin
          col_cnt <= c_inc[AW-1:0];
          row_cnt <= r_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px_l  <= pixel;
      r_cur <= r0;
      c_cur <= c0;
    end
  end

  // status back to the sequencer: root finished, result pending, output free
  assign stat = {(sq_bit == '0), pend_emit, (!out_valid || out_ready)};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      edge_value <= pend_val;
      out_row    <= pend_y;
      out_col    <= pend_x;
      sector     <= pend_sec;
    end
  end

endmodule

/* src/sobel_nonmax_suppression_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_nonmax_suppression_top
// Sobel gradient with non-maximum suppression on a raster pixel stream.
// Each item runs through five set-up steps, the integer root (11 steps and
// the finish check), magnitude, update, emit and the accepting idle state,
// and no new item is taken before then; emit waits while the output is full.
// A result may wait on out_valid while the next item is taken.
// Synchronous reset clears counters, windows and the width register (640);
// line buffers need no clearing.
// ----------------------------------------------------------------------------
module sobel_nonmax_suppression_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  edge_value,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic [1:0]  sector
);

  logic [10:0]      image_width;
  logic             reg_sel;
  sns_pkg::cmd_t    cmd;
  sns_pkg::status_t stat;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr == 2'(sns_pkg::REG_IMAGE_WIDTH * 4));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= sns_pkg::WIDTH_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      image_width <= pwdata[10:0];
    end
  end

  assign prdata = reg_sel ? {21'b0, image_width} : 32'b0;

  sns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sns_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .image_width (image_width),
    .pixel       (pixel),
    .frame_start (frame_start),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .edge_value  (edge_value),
    .out_row     (out_row),
    .out_col     (out_col),
    .sector      (sector)
  );

endmodule
